@@ design/table_interpolator_core_defines.svh @@
// Assertion macros shared by the table interpolator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TABLE_INTERPOLATOR_CORE_DEFINES_SVH
`define TABLE_INTERPOLATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TIC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tic_pkg.sv @@
// Shared types and constants for the table interpolator.
// No dependencies; imported by every module of the block.
package tic_pkg;

    localparam int DATA_W     = 32;
    localparam int WIDE_W     = 64;
    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int PIU_W      = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM_GRID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRAPOLATE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [PIU_W-1:0] PIU_RESET = 9'd256;

    // Query sequencer
    typedef enum logic [4:0] {
        ST_IDLE, ST_LD0, ST_LD1, ST_LD2, ST_DIV_GO, ST_DIV_WAIT,
        ST_LDN, ST_LDN_CAP, ST_BS_RD, ST_BS_CMP, ST_RESOLVE,
        ST_PT_RD, ST_PT_CAP, ST_NV_CHK, ST_NV_GO, ST_NV_WAIT, ST_FIN
    } ctl_state_t;

    // Serial multiply-divide unit
    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_DONE} md_state_t;

    // Where the query sits relative to the table
    typedef enum logic [1:0] {WH_IN, WH_LOW, WH_HIGH} where_t;

    // How node abscissae are formed
    typedef enum logic [1:0] {GM_TABLE, GM_STEP, GM_GRID} gmode_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_stat_t;

endpackage

@@ design/tic_table.sv @@
// Point table: x and y memories, one write port, one registered read port.
// Depends on tic_pkg.
module tic_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [tic_pkg::DATA_W-1:0] wx,
    input  logic [tic_pkg::DATA_W-1:0] wy,
    input  logic [AW-1:0]             raddr,
    output logic [tic_pkg::DATA_W-1:0] rx,
    output logic [tic_pkg::DATA_W-1:0] ry
);
    import tic_pkg::*;

    logic [DATA_W-1:0] x_mem [DEPTH];
    logic [DATA_W-1:0] y_mem [DEPTH];
    logic [DATA_W-1:0] rd_x_reg;
    logic [DATA_W-1:0] rd_y_reg;

    // Write a point, read one entry per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            x_mem[waddr] <= wx;
            y_mem[waddr] <= wy;
        end
        rd_x_reg <= x_mem[raddr];
        rd_y_reg <= y_mem[raddr];
    end

    assign rx = rd_x_reg;
    assign ry = rd_y_reg;

endmodule

@@ design/tic_muldiv.sv @@
// Serial trunc(a*b/d): shift-add multiply, then restoring divide, one bit a cycle.
// Depends on tic_pkg.
module tic_muldiv #(
    parameter int BW = 44
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [tic_pkg::WIDE_W-1:0] a,
    input  logic signed [BW-1:0]              b,
    input  logic signed [BW-1:0]              d,
    output tic_pkg::md_stat_t                 stat,
    output logic signed [tic_pkg::WIDE_W-1:0] quot,
    output logic [BW-1:0]                     rem_mag
);
    import tic_pkg::*;

    localparam int PW = WIDE_W + BW;
    localparam int CW = $clog2(PW + 1);

    md_state_t         state_reg, state_next;
    logic [CW-1:0]     cnt_reg;
    logic [PW-1:0]     mcand_reg;
    logic [BW-1:0]     mplier_reg;
    logic [PW-1:0]     prod_reg;
    logic [BW-1:0]     ud_reg;
    logic [BW-1:0]     rem_reg;
    logic [WIDE_W-1:0] ql_reg;
    logic              ovf_reg;
    logic              neg_reg;

    logic [WIDE_W-1:0] ua;
    logic [BW-1:0]     ub;
    logic [BW-1:0]     ud;
    logic [BW:0]       r2;
    logic [BW:0]       r2_sub;
    logic              ge;
    logic [WIDE_W-1:0] r_mag;

    // Operand magnitudes
    assign ua = a[WIDE_W-1] ? (~a + 1'b1) : a;
    assign ub = b[BW-1] ? (~b + 1'b1) : b;
    assign ud = d[BW-1] ? (~d + 1'b1) : d;

    // One restoring division step
    assign r2     = {rem_reg, prod_reg[PW-1]};
    assign r2_sub = r2 - {1'b0, ud_reg};
    assign ge     = (r2 >= {1'b0, ud_reg});

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE: if (start) state_next = MD_MUL;
            MD_MUL:  if (cnt_reg == CW'(BW - 1)) state_next = MD_DIV;
            MD_DIV:  if (cnt_reg == CW'(PW - 1)) state_next = MD_DONE;
            MD_DONE: state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    // Status and result
    always_comb begin
        stat.busy = (state_reg != MD_IDLE);
        stat.done = (state_reg == MD_DONE);
        r_mag     = (ovf_reg || ql_reg[WIDE_W-1]) ? {1'b0, {(WIDE_W-1){1'b1}}} : ql_reg;
        quot      = neg_reg ? $signed(~r_mag + 1'b1) : $signed(r_mag);
        rem_mag   = rem_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath: load, accumulate partial products, then shift out quotient bits
    always_ff @(posedge aclk) begin
        case (state_reg)
            MD_IDLE: begin
                mcand_reg  <= {{BW{1'b0}}, ua};
                mplier_reg <= ub;
                prod_reg   <= '0;
                ud_reg     <= ud;
                rem_reg    <= '0;
                ql_reg     <= '0;
                ovf_reg    <= 1'b0;
                neg_reg    <= a[WIDE_W-1] ^ b[BW-1] ^ d[BW-1];
                cnt_reg    <= '0;
            end
            MD_MUL: begin
                if (mplier_reg[0]) begin
                    prod_reg <= prod_reg + mcand_reg;
                end
                mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[BW-1:1]};
                cnt_reg    <= (cnt_reg == CW'(BW - 1)) ? '0 : cnt_reg + 1'b1;
            end
            MD_DIV: begin
                rem_reg  <= ge ? r2_sub[BW-1:0] : r2[BW-1:0];
                prod_reg <= {prod_reg[PW-2:0], 1'b0};
                ovf_reg  <= ovf_reg | ql_reg[WIDE_W-1];
                ql_reg   <= {ql_reg[WIDE_W-2:0], ge};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

endmodule

@@ design/table_interpolator_core.sv @@
// Top level of the table interpolator: config registers, query sequencer,
// Neville evaluation. Depends on tic_pkg, tic_table, tic_muldiv.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------
//  s_       | in        | s_tvalid / s_tready  | s_tuser op, s_tdata point/query
//  m_       | out       | m_tvalid / m_tready  | m_tdata value, m_tuser out_of_range
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A write item gives no result. A query reads the table through one memory
// port: setup loads points 0 and 1, then either a serial divide (uniform
// grid) or a read of the last point and a binary search that reads one point
// per step; then each point used is loaded and one multiply-divide pass runs
// per interpolation step (1 linear, 3 quadratic, 6 cubic). The multiply-divide
// width is GW = log2(TABLE_DEPTH)+36. Reset is synchronous and needs no sweep.
// A result waiting on m_tready stalls only the next query at its last step.
`include "table_interpolator_core_defines.svh"

module table_interpolator_core #(
    parameter int TABLE_DEPTH = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] point_index, [39:8] point_x, [71:40] point_y, [103:72] query_x
    input  logic [tic_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] op
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] value
    output logic [tic_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] out_of_range
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tic_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tic_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;
    localparam int GW = AW + 36;
    localparam int SW = (VALUE_WIDTH > DATA_W) ? DATA_W : VALUE_WIDTH;
    localparam logic signed [WIDE_W-1:0] VLIM = (64'sd1 <<< (SW - 1)) - 64'sd1;
    localparam logic signed [WIDE_W-1:0] VMIN = -VLIM - 64'sd1;

    // Configuration
    logic             kind_reg;
    logic             uni_reg;
    logic             ext_reg;
    logic [PIU_W-1:0] piu_reg;

    // Sequencer and datapath registers
    ctl_state_t               state_reg, state_next;
    logic signed [DATA_W-1:0] q_reg;
    logic [NW-1:0]            n_reg;
    logic signed [DATA_W-1:0] x0_reg;
    logic signed [DATA_W:0]   dx_reg;
    logic [AW-1:0]            lo_reg;
    logic [AW-1:0]            hi_reg;
    logic [AW-1:0]            idx_reg;
    where_t                   where_reg;
    logic [AW-1:0]            s_reg;
    logic [1:0]               km1_reg;
    gmode_t                   gm_reg;
    logic [1:0]               j_reg;
    logic [1:0]               lv_reg;
    logic signed [WIDE_W-1:0] p_reg [4];
    logic signed [GW-1:0]     g_reg [4];
    logic                     oor_reg;
    logic                     m_tvalid_reg;
    logic [DATA_W-1:0]        m_value_reg;
    logic                     m_oor_reg;

    // Table and muldiv connections
    logic                     tbl_we;
    logic [AW-1:0]            tbl_waddr;
    logic [AW-1:0]            tbl_raddr;
    logic [DATA_W-1:0]        rd_x;
    logic [DATA_W-1:0]        rd_y;
    logic                     md_start;
    logic signed [WIDE_W-1:0] md_a;
    logic signed [GW-1:0]     md_b;
    logic signed [GW-1:0]     md_d;
    md_stat_t                 md_stat;
    logic signed [WIDE_W-1:0] md_quot;
    logic [GW-1:0]            md_rem;

    // Combinational decisions
    logic                     s_acc;
    logic [NW-1:0]            n_clamp;
    logic signed [DATA_W:0]   ld2_dx;
    logic                     ld2_hit;
    logic                     q_lt_x0;
    logic signed [WIDE_W-1:0] n_s;
    logic signed [WIDE_W-1:0] qt_w;
    where_t                   div_where;
    logic [AW-1:0]            div_idx;
    logic                     q_gt_xl;
    logic [AW:0]              mid_sum;
    logic [AW-1:0]            mid;
    logic                     bs_lt;
    logic [AW-1:0]            lo_n;
    logic [AW-1:0]            hi_n;
    logic                     bs_more;
    logic [AW-1:0]            nm1;
    logic [AW-1:0]            nm2;
    logic [AW-1:0]            res_idx;
    logic                     res_oor;
    logic                     res_lin;
    logic [AW-1:0]            res_s;
    logic [1:0]               res_km1;
    gmode_t                   res_gm;
    logic signed [GW-1:0]     q_g;
    logic signed [GW-1:0]     dx_g;
    logic signed [AW+33:0]    grid_prod;
    logic signed [GW-1:0]     g_new;
    logic signed [GW-1:0]     ga;
    logic signed [GW-1:0]     gb;
    logic signed [GW-1:0]     den_w;
    logic [2:0]               jl_sum;
    logic                     nv_more_j;
    logic                     nv_more_lv;
    logic                     nv_last;
    logic signed [WIDE_W-1:0] v_sat;

    function automatic logic signed [WIDE_W-1:0] sat_add64(
        input logic signed [WIDE_W-1:0] x,
        input logic signed [WIDE_W-1:0] y
    );
        logic [WIDE_W:0] s;
        s = {x[WIDE_W-1], x} + {y[WIDE_W-1], y};
        if (s[WIDE_W] != s[WIDE_W-1]) begin
            sat_add64 = s[WIDE_W] ? {1'b1, {(WIDE_W-1){1'b0}}} : {1'b0, {(WIDE_W-1){1'b1}}};
        end else begin
            sat_add64 = s[WIDE_W-1:0];
        end
    endfunction

    function automatic logic signed [WIDE_W-1:0] sat_sub64(
        input logic signed [WIDE_W-1:0] x,
        input logic signed [WIDE_W-1:0] y
    );
        logic [WIDE_W:0] s;
        s = {x[WIDE_W-1], x} - {y[WIDE_W-1], y};
        if (s[WIDE_W] != s[WIDE_W-1]) begin
            sat_sub64 = s[WIDE_W] ? {1'b1, {(WIDE_W-1){1'b0}}} : {1'b0, {(WIDE_W-1){1'b1}}};
        end else begin
            sat_sub64 = s[WIDE_W-1:0];
        end
    endfunction

    tic_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wx    (s_tdata[39:8]),
        .wy    (s_tdata[71:40]),
        .raddr (tbl_raddr),
        .rx    (rd_x),
        .ry    (rd_y)
    );

    tic_muldiv #(
        .BW (GW)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .a       (md_a),
        .b       (md_b),
        .d       (md_d),
        .stat    (md_stat),
        .quot    (md_quot),
        .rem_mag (md_rem)
    );

    // Write path into the table
    assign s_acc     = s_tvalid && s_tready;
    assign tbl_we    = s_acc && (s_tuser == OP_WRITE)
                       && ({24'd0, s_tdata[7:0]} < 32'(TABLE_DEPTH));
    assign tbl_waddr = AW'(s_tdata[7:0]);

    // Clamp the point count
    always_comb begin
        if (piu_reg == '0) begin
            n_clamp = NW'(1);
        end else if ({23'd0, piu_reg} > 32'(TABLE_DEPTH)) begin
            n_clamp = NW'(TABLE_DEPTH);
        end else begin
            n_clamp = NW'(piu_reg);
        end
    end

    // Left end and grid step
    assign ld2_dx  = $signed({rd_x[DATA_W-1], rd_x}) - $signed({x0_reg[DATA_W-1], x0_reg});
    assign q_lt_x0 = q_reg < x0_reg;
    assign ld2_hit = (ld2_dx > 0) && (q_reg == x0_reg);
    assign nm1     = AW'(n_reg - NW'(1));
    assign nm2     = AW'(n_reg - NW'(2));

    // Floor the quotient and classify the uniform-grid segment
    assign n_s  = $signed({{(WIDE_W-NW){1'b0}}, n_reg});
    assign qt_w = md_quot - (((q_lt_x0) && (md_rem != '0)) ? 64'sd1 : 64'sd0);
    always_comb begin
        div_where = WH_HIGH;
        div_idx   = nm2;
        if (qt_w < 0) begin
            div_where = WH_LOW;
        end else if (qt_w <= n_s - 64'sd2) begin
            div_where = WH_IN;
            div_idx   = qt_w[AW-1:0];
        end else if ((qt_w == n_s - 64'sd1) && (md_rem == '0)) begin
            div_where = WH_IN;
        end
    end

    // Binary search step
    assign q_gt_xl = q_reg > $signed(rd_x);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[AW:1];
    assign bs_lt   = $signed(rd_x) < q_reg;
    assign lo_n    = bs_lt ? mid : lo_reg;
    assign hi_n    = bs_lt ? hi_reg : mid;
    assign bs_more = (hi_n - lo_n) > AW'(1);

    // Pick the points and node form for the evaluation
    always_comb begin
        res_oor = (where_reg != WH_IN) && !ext_reg;
        case (where_reg)
            WH_LOW:  res_idx = '0;
            WH_HIGH: res_idx = nm2;
            default: res_idx = idx_reg;
        endcase
        res_lin = !kind_reg || (where_reg != WH_IN) || (n_reg < NW'(3))
                  || (!uni_reg && ((res_idx == '0) || (res_idx == nm2)));
        res_s   = res_idx;
        res_km1 = 2'd1;
        res_gm  = GM_TABLE;
        if (!kind_reg && uni_reg) begin
            res_gm = GM_STEP;
        end else if (res_lin) begin
            res_gm = GM_TABLE;
        end else if (uni_reg) begin
            res_gm = GM_GRID;
            if (res_idx == '0) begin
                res_s   = '0;
                res_km1 = 2'd2;
            end else if (res_idx == nm2) begin
                res_s   = AW'(n_reg - NW'(3));
                res_km1 = 2'd2;
            end else begin
                res_s   = res_idx - AW'(1);
                res_km1 = 2'd3;
            end
        end else begin
            res_s   = res_idx - AW'(1);
            res_km1 = 2'd3;
        end
    end

    // Node abscissa for the point being loaded
    assign q_g       = {{(GW-DATA_W){q_reg[DATA_W-1]}}, q_reg};
    assign dx_g      = {{(GW-DATA_W-1){dx_reg[DATA_W]}}, dx_reg};
    assign grid_prod = $signed({1'b0, s_reg}) * dx_reg;
    always_comb begin
        case (gm_reg)
            GM_STEP: begin
                g_new = (j_reg == 2'd0) ? {{(GW-DATA_W){rd_x[DATA_W-1]}}, rd_x}
                                        : g_reg[0] + dx_g;
            end
            GM_GRID: begin
                g_new = (j_reg == 2'd0)
                        ? {{(GW-DATA_W){x0_reg[DATA_W-1]}}, x0_reg} + GW'(grid_prod)
                        : g_reg[j_reg - 2'd1] + dx_g;
            end
            default: begin
                g_new = {{(GW-DATA_W){rd_x[DATA_W-1]}}, rd_x};
            end
        endcase
    end

    // Neville step operands and loop control
    assign ga         = g_reg[j_reg];
    assign gb         = g_reg[j_reg + lv_reg];
    assign den_w      = gb - ga;
    assign jl_sum     = {1'b0, j_reg} + {1'b0, lv_reg};
    assign nv_more_j  = jl_sum < {1'b0, km1_reg};
    assign nv_more_lv = lv_reg < km1_reg;
    assign nv_last    = !nv_more_j && !nv_more_lv;

    // Saturate the final value
    assign v_sat = (p_reg[0] > VLIM) ? VLIM : ((p_reg[0] < VMIN) ? VMIN : p_reg[0]);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_tuser == OP_QUERY)) state_next = ST_LD0;
            end
            ST_LD0: state_next = ST_LD1;
            ST_LD1: state_next = (n_reg == NW'(1)) ? ST_FIN : ST_LD2;
            ST_LD2: begin
                if (ld2_hit) begin
                    state_next = ST_FIN;
                end else if (uni_reg) begin
                    state_next = (ld2_dx <= 0) ? ST_RESOLVE : ST_DIV_GO;
                end else begin
                    state_next = ST_LDN;
                end
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (md_stat.done) state_next = ST_RESOLVE;
            ST_LDN:      state_next = ST_LDN_CAP;
            ST_LDN_CAP: begin
                if (q_gt_xl || q_lt_x0 || (nm1 <= AW'(1))) begin
                    state_next = ST_RESOLVE;
                end else begin
                    state_next = ST_BS_RD;
                end
            end
            ST_BS_RD:   state_next = ST_BS_CMP;
            ST_BS_CMP:  state_next = bs_more ? ST_BS_RD : ST_RESOLVE;
            ST_RESOLVE: state_next = res_oor ? ST_FIN : ST_PT_RD;
            ST_PT_RD:   state_next = ST_PT_CAP;
            ST_PT_CAP:  state_next = (j_reg == km1_reg) ? ST_NV_CHK : ST_PT_RD;
            ST_NV_CHK: begin
                if (den_w != '0) begin
                    state_next = ST_NV_GO;
                end else begin
                    state_next = nv_last ? ST_FIN : ST_NV_CHK;
                end
            end
            ST_NV_GO: state_next = ST_NV_WAIT;
            ST_NV_WAIT: begin
                if (md_stat.done) state_next = nv_last ? ST_FIN : ST_NV_CHK;
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, read address, muldiv request
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        tbl_raddr = '0;
        md_start  = 1'b0;
        md_a      = sat_sub64(p_reg[j_reg + 2'd1], p_reg[j_reg]);
        md_b      = q_g - ga;
        md_d      = den_w;
        case (state_reg)
            ST_LD1:   tbl_raddr = AW'(1);
            ST_LDN:   tbl_raddr = nm1;
            ST_BS_RD: tbl_raddr = mid;
            ST_PT_RD: tbl_raddr = s_reg + AW'(j_reg);
            ST_DIV_GO: begin
                md_start = 1'b1;
                md_a     = 64'sd1;
                md_b     = q_g - {{(GW-DATA_W){x0_reg[DATA_W-1]}}, x0_reg};
                md_d     = dx_g;
            end
            ST_NV_GO: md_start = 1'b1;
            default:  tbl_raddr = '0;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_value_reg;
    assign m_tuser   = m_oor_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kind_reg     <= 1'b0;
            uni_reg      <= 1'b1;
            ext_reg      <= 1'b0;
            piu_reg      <= PIU_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_INTERP_KIND:   kind_reg <= cfg_data[0];
                    CFG_UNIFORM_GRID:  uni_reg  <= cfg_data[0];
                    CFG_EXTRAPOLATE:   ext_reg  <= cfg_data[0];
                    CFG_POINTS_IN_USE: piu_reg  <= cfg_data;
                    default:           piu_reg  <= piu_reg;
                endcase
            end
            // Hold the result until taken, load a new one at the end of a query
            if ((state_reg == ST_FIN) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Query datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                q_reg   <= $signed(s_tdata[103:72]);
                n_reg   <= n_clamp;
                oor_reg <= 1'b0;
            end
            ST_LD1: begin
                x0_reg   <= $signed(rd_x);
                p_reg[0] <= {{(WIDE_W-DATA_W){rd_y[DATA_W-1]}}, rd_y};
            end
            ST_LD2: begin
                dx_reg    <= ld2_dx;
                where_reg <= q_lt_x0 ? WH_LOW : WH_HIGH;
            end
            ST_DIV_WAIT: begin
                where_reg <= div_where;
                idx_reg   <= div_idx;
            end
            ST_LDN_CAP: begin
                lo_reg    <= '0;
                hi_reg    <= nm1;
                idx_reg   <= '0;
                where_reg <= q_gt_xl ? WH_HIGH : (q_lt_x0 ? WH_LOW : WH_IN);
            end
            ST_BS_CMP: begin
                lo_reg  <= lo_n;
                hi_reg  <= hi_n;
                idx_reg <= lo_n;
            end
            ST_RESOLVE: begin
                oor_reg  <= res_oor;
                p_reg[0] <= '0;
                s_reg    <= res_s;
                km1_reg  <= res_km1;
                gm_reg   <= res_gm;
                j_reg    <= '0;
            end
            ST_PT_CAP: begin
                p_reg[j_reg] <= {{(WIDE_W-DATA_W){rd_y[DATA_W-1]}}, rd_y};
                g_reg[j_reg] <= g_new;
                j_reg        <= (j_reg == km1_reg) ? 2'd0 : j_reg + 2'd1;
                lv_reg       <= 2'd1;
            end
            ST_NV_CHK, ST_NV_WAIT: begin
                // Advance the Neville indices after a step completes or is skipped
                if (((state_reg == ST_NV_CHK) && (den_w == '0))
                    || ((state_reg == ST_NV_WAIT) && md_stat.done)) begin
                    if (state_reg == ST_NV_WAIT) begin
                        p_reg[j_reg] <= sat_add64(p_reg[j_reg], md_quot);
                    end
                    if (nv_more_j) begin
                        j_reg <= j_reg + 2'd1;
                    end else if (nv_more_lv) begin
                        lv_reg <= lv_reg + 2'd1;
                        j_reg  <= '0;
                    end
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_value_reg <= oor_reg ? '0 : v_sat[DATA_W-1:0];
                    m_oor_reg   <= oor_reg;
                end
            end
            default: begin
                lo_reg <= lo_reg;
            end
        endcase
    end

    `TIC_ASSERT_IMPLIES(a_md_done_in_wait, aclk, aresetn, md_stat.done, ((state_reg == ST_DIV_WAIT) || (state_reg == ST_NV_WAIT)), "muldiv finished outside a wait state")
    `TIC_ASSERT_IMPLIES(a_oor_value_zero, aclk, aresetn, (m_tvalid_reg && m_oor_reg), (m_value_reg == '0), "out-of-range result carries a nonzero value")
    `TIC_ASSERT_NEXT(a_fin_loads_result, aclk, aresetn, ((state_reg == ST_FIN) && (!m_tvalid_reg || m_tready)), m_tvalid_reg, "finished query did not present a result")
    `TIC_ASSERT_IMPLIES(a_nv_index_range, aclk, aresetn, (state_reg == ST_NV_CHK), (({1'b0, j_reg} + {1'b0, lv_reg}) <= {1'b0, km1_reg}), "Neville index past loaded points")

endmodule
